@@ rtl/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under active-low reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication under active-low reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ rtl/glcm_pkg.sv @@
`default_nettype none

package glcm_pkg;

  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PROD_W   = DATA_W + VALUE_W;
  localparam int unsigned GSIZE_W  = 4;
  localparam int unsigned PC_W     = 5;
  localparam int unsigned OP_W     = 4;
  localparam int unsigned COND_W   = 4;
  localparam int unsigned DCNT_W   = 5;

  localparam logic [GSIZE_W-1:0] MAX_GROUP = 4'd15;
  localparam logic [GSIZE_W-1:0] MIN_GROUP = 4'd2;

  // datapath operations
  localparam logic [OP_W-1:0] OP_NOP     = 4'd0;
  localparam logic [OP_W-1:0] OP_WAIT    = 4'd1;
  localparam logic [OP_W-1:0] OP_ECHO    = 4'd2;
  localparam logic [OP_W-1:0] OP_LOAD_AB = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV_AB  = 4'd4;
  localparam logic [OP_W-1:0] OP_DIV_STP = 4'd5;
  localparam logic [OP_W-1:0] OP_SWAP    = 4'd6;
  localparam logic [OP_W-1:0] OP_DIV_MG  = 4'd7;
  localparam logic [OP_W-1:0] OP_MUL     = 4'd8;
  localparam logic [OP_W-1:0] OP_SAT     = 4'd9;
  localparam logic [OP_W-1:0] OP_FIRST   = 4'd10;
  localparam logic [OP_W-1:0] OP_ZERO    = 4'd11;
  localparam logic [OP_W-1:0] OP_POSINC  = 4'd12;
  localparam logic [OP_W-1:0] OP_PAD     = 4'd13;
  localparam logic [OP_W-1:0] OP_MULT    = 4'd14;

  // jump conditions
  localparam logic [COND_W-1:0] C_NEVER      = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS     = 4'd1;
  localparam logic [COND_W-1:0] C_NO_INPUT   = 4'd2;
  localparam logic [COND_W-1:0] C_POS_ZERO   = 4'd3;
  localparam logic [COND_W-1:0] C_ZERO_OPND  = 4'd4;
  localparam logic [COND_W-1:0] C_OVF        = 4'd5;
  localparam logic [COND_W-1:0] C_A_ZERO     = 4'd6;
  localparam logic [COND_W-1:0] C_DIV_MORE   = 4'd7;
  localparam logic [COND_W-1:0] C_CLOSE      = 4'd8;
  localparam logic [COND_W-1:0] C_NOT_LAST   = 4'd9;
  localparam logic [COND_W-1:0] C_POS_LT_SZ  = 4'd10;

  // program labels
  localparam logic [PC_W-1:0] S_WAIT   = 5'd0;
  localparam logic [PC_W-1:0] S_GCD    = 5'd6;
  localparam logic [PC_W-1:0] S_GLOOP  = 5'd8;
  localparam logic [PC_W-1:0] S_QUOT   = 5'd10;
  localparam logic [PC_W-1:0] S_QLOOP  = 5'd11;
  localparam logic [PC_W-1:0] S_FIRST  = 5'd14;
  localparam logic [PC_W-1:0] S_ZERO   = 5'd15;
  localparam logic [PC_W-1:0] S_POSINC = 5'd16;
  localparam logic [PC_W-1:0] S_PAD    = 5'd19;
  localparam logic [PC_W-1:0] S_MULT   = 5'd21;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      5'd0:    w = '{OP_WAIT,    C_NO_INPUT,  S_WAIT};
      5'd1:    w = '{OP_ECHO,    C_NEVER,     S_WAIT};
      5'd2:    w = '{OP_NOP,     C_POS_ZERO,  S_FIRST};
      5'd3:    w = '{OP_NOP,     C_ZERO_OPND, S_ZERO};
      5'd4:    w = '{OP_NOP,     C_OVF,       S_POSINC};
      5'd5:    w = '{OP_LOAD_AB, C_NEVER,     S_WAIT};
      5'd6:    w = '{OP_NOP,     C_A_ZERO,    S_QUOT};
      5'd7:    w = '{OP_DIV_AB,  C_NEVER,     S_WAIT};
      5'd8:    w = '{OP_DIV_STP, C_DIV_MORE,  S_GLOOP};
      5'd9:    w = '{OP_SWAP,    C_ALWAYS,    S_GCD};
      5'd10:   w = '{OP_DIV_MG,  C_NEVER,     S_WAIT};
      5'd11:   w = '{OP_DIV_STP, C_DIV_MORE,  S_QLOOP};
      5'd12:   w = '{OP_MUL,     C_NEVER,     S_WAIT};
      5'd13:   w = '{OP_SAT,     C_ALWAYS,    S_POSINC};
      5'd14:   w = '{OP_FIRST,   C_ALWAYS,    S_POSINC};
      5'd15:   w = '{OP_ZERO,    C_NEVER,     S_WAIT};
      5'd16:   w = '{OP_POSINC,  C_NEVER,     S_WAIT};
      5'd17:   w = '{OP_NOP,     C_CLOSE,     S_MULT};
      5'd18:   w = '{OP_NOP,     C_NOT_LAST,  S_WAIT};
      5'd19:   w = '{OP_PAD,     C_NEVER,     S_WAIT};
      5'd20:   w = '{OP_NOP,     C_POS_LT_SZ, S_PAD};
      5'd21:   w = '{OP_MULT,    C_ALWAYS,    S_WAIT};
      default: w = '{OP_NOP,     C_ALWAYS,    S_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ rtl/glcm_if.sv @@
`default_nettype none

interface glcm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [glcm_pkg::VALUE_W-1:0]         value;
  logic                                 last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface glcm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [glcm_pkg::DATA_W-1:0]          out_value;
  logic                                 is_multiple;
  logic                                 overflowed;
  logic                                 last_of_run;

  modport source (output valid, output out_value, output is_multiple,
                  output overflowed, output last_of_run, input ready);
  modport sink   (input valid, input out_value, input is_multiple,
                  input overflowed, input last_of_run, output ready);
endinterface

`default_nettype wire

@@ rtl/group_lcm_appender_top.sv @@
`default_nettype none

// Echoes each 16-bit input word and, after every group of cfg group size words
// (clamped to 2..15), emits the group's least common multiple, saturated at
// 32 bits with a flag; a last_item word that leaves the group short is followed
// by zero padding words and a multiple of 0. A microcoded sequencer drives one
// shared radix-2 divider. A word that needs no Euclid step (first word of a
// group, a zero operand, or a group already saturated) skips the divider;
// otherwise each Euclid round and the final quotient run on the divider, with a
// shorter pass when the dividend fits in 16 bits. The time an item takes depends
// on the number of Euclid rounds on the running multiple and the input word.
// A result stalled at the output holds the sequencer at its next emit step.
// One item is worked at a time; the next is taken while the last result still
// waits in the output register.

`include "assert_macros.svh"

module group_lcm_appender_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [glcm_pkg::GSIZE_W-1:0] cfg_wdata,
  glcm_in_if.sink                           in_ch,
  glcm_out_if.source                        out_ch
);

  localparam int unsigned VW = glcm_pkg::VALUE_W;
  localparam int unsigned DW = glcm_pkg::DATA_W;
  localparam int unsigned PW = glcm_pkg::PROD_W;
  localparam int unsigned GW = glcm_pkg::GSIZE_W;

  glcm_pkg::ctrl_t ctrl;

  logic [glcm_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [GW-1:0]               gsize_r, gsize_nxt;
  logic [DW-1:0]               mult_r, mult_nxt;
  logic [GW-1:0]               pos_r, pos_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [VW-1:0]               val_r, val_nxt;
  logic                        last_r, last_nxt;
  logic [DW-1:0]               a_r, a_nxt;
  logic [DW-1:0]               b_r, b_nxt;
  logic [DW-1:0]               dv_r, dv_nxt;
  logic [DW-1:0]               rem_r, rem_nxt;
  logic [DW-1:0]               quo_r, quo_nxt;
  logic [glcm_pkg::DCNT_W-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]               prod_r, prod_nxt;
  logic                        ov_r, ov_nxt;
  logic [DW-1:0]               ov_value_r, ov_value_nxt;
  logic                        ov_mult_r, ov_mult_nxt;
  logic                        ov_flag_r, ov_flag_nxt;
  logic                        ov_last_r, ov_last_nxt;

  logic [GW-1:0]               size_eff;
  logic                        out_free;
  logic                        emit_op;
  logic                        stall;
  logic                        jump;
  logic                        close_now;
  logic                        close_echo;
  logic [DW:0]                 div_sh;
  logic                        div_ge;
  logic [DW:0]                 div_diff;
  logic [DW-1:0]               div_src;
  logic [DW-1:0]               div_dvs;
  logic                        div_narrow;

  assign ctrl = glcm_pkg::ucode(pc_r);

  always_comb begin
    size_eff = gsize_r;
    if (gsize_r < glcm_pkg::MIN_GROUP) begin
      size_eff = glcm_pkg::MIN_GROUP;
    end else if (gsize_r > glcm_pkg::MAX_GROUP) begin
      size_eff = glcm_pkg::MAX_GROUP;
    end
  end

  assign close_now  = pos_r >= size_eff;
  assign close_echo = ({1'b0, pos_r} + 5'd1) >= {1'b0, size_eff};

  assign out_free = !ov_r || out_ch.ready;
  assign emit_op  = (ctrl.op == glcm_pkg::OP_ECHO) || (ctrl.op == glcm_pkg::OP_PAD) ||
                    (ctrl.op == glcm_pkg::OP_MULT);
  assign stall    = emit_op && !out_free;

  assign in_ch.ready = (ctrl.op == glcm_pkg::OP_WAIT);

  assign out_ch.valid       = ov_r;
  assign out_ch.out_value   = ov_value_r;
  assign out_ch.is_multiple = ov_mult_r;
  assign out_ch.overflowed  = ov_flag_r;
  assign out_ch.last_of_run = ov_last_r;

  always_comb begin
    case (ctrl.cond)
      glcm_pkg::C_NEVER:     jump = 1'b0;
      glcm_pkg::C_ALWAYS:    jump = 1'b1;
      glcm_pkg::C_NO_INPUT:  jump = !in_ch.valid;
      glcm_pkg::C_POS_ZERO:  jump = (pos_r == '0);
      glcm_pkg::C_ZERO_OPND: jump = (val_r == '0) || (mult_r == '0);
      glcm_pkg::C_OVF:       jump = ovf_r;
      glcm_pkg::C_A_ZERO:    jump = (a_r == '0);
      glcm_pkg::C_DIV_MORE:  jump = (cnt_r != '0);
      glcm_pkg::C_CLOSE:     jump = close_now;
      glcm_pkg::C_NOT_LAST:  jump = !last_r;
      glcm_pkg::C_POS_LT_SZ: jump = !close_now;
      default:               jump = 1'b0;
    endcase
  end

  always_comb begin
    if (stall) begin
      pc_nxt = pc_r;
    end else if (jump) begin
      pc_nxt = ctrl.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  // shared restoring divider
  assign div_sh   = {rem_r, quo_r[DW-1]};
  assign div_ge   = div_sh >= {1'b0, dv_r};
  assign div_diff = div_sh - {1'b0, dv_r};

  always_comb begin
    if (ctrl.op == glcm_pkg::OP_DIV_MG) begin
      div_src = mult_r;
      div_dvs = b_r;
    end else begin
      div_src = b_r;
      div_dvs = a_r;
    end
  end

  assign div_narrow = (div_src[DW-1:VW] == '0);

  always_comb begin
    gsize_nxt    = cfg_we ? cfg_wdata : gsize_r;
    mult_nxt     = mult_r;
    pos_nxt      = pos_r;
    ovf_nxt      = ovf_r;
    val_nxt      = val_r;
    last_nxt     = last_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    dv_nxt       = dv_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    cnt_nxt      = cnt_r;
    prod_nxt     = prod_r;
    ov_nxt       = out_ch.ready ? 1'b0 : ov_r;
    ov_value_nxt = ov_value_r;
    ov_mult_nxt  = ov_mult_r;
    ov_flag_nxt  = ov_flag_r;
    ov_last_nxt  = ov_last_r;
    if (!stall) begin
      case (ctrl.op)
        glcm_pkg::OP_WAIT: begin
          if (in_ch.valid) begin
            val_nxt  = in_ch.value;
            last_nxt = in_ch.last_item;
          end
        end
        glcm_pkg::OP_ECHO: begin
          ov_nxt       = 1'b1;
          ov_value_nxt = {{(DW-VW){1'b0}}, val_r};
          ov_mult_nxt  = 1'b0;
          ov_flag_nxt  = 1'b0;
          ov_last_nxt  = !close_echo && !last_r;
        end
        glcm_pkg::OP_LOAD_AB: begin
          a_nxt = mult_r;
          b_nxt = {{(DW-VW){1'b0}}, val_r};
        end
        glcm_pkg::OP_DIV_AB, glcm_pkg::OP_DIV_MG: begin
          dv_nxt  = div_dvs;
          rem_nxt = '0;
          quo_nxt = div_narrow ? {div_src[VW-1:0], {(DW-VW){1'b0}}} : div_src;
          cnt_nxt = div_narrow ? glcm_pkg::DCNT_W'(VW - 1) : glcm_pkg::DCNT_W'(DW - 1);
        end
        glcm_pkg::OP_DIV_STP: begin
          rem_nxt = div_ge ? div_diff[DW-1:0] : div_sh[DW-1:0];
          quo_nxt = {quo_r[DW-2:0], div_ge};
          cnt_nxt = cnt_r - 1'b1;
        end
        glcm_pkg::OP_SWAP: begin
          b_nxt = a_r;
          a_nxt = rem_r;
        end
        glcm_pkg::OP_MUL: begin
          prod_nxt = {{(PW-DW){1'b0}}, quo_r} * {{(PW-VW){1'b0}}, val_r};
        end
        glcm_pkg::OP_SAT: begin
          if (prod_r[PW-1:DW] != '0) begin
            mult_nxt = '1;
            ovf_nxt  = 1'b1;
          end else begin
            mult_nxt = prod_r[DW-1:0];
          end
        end
        glcm_pkg::OP_FIRST: begin
          mult_nxt = {{(DW-VW){1'b0}}, val_r};
          ovf_nxt  = 1'b0;
        end
        glcm_pkg::OP_ZERO: begin
          mult_nxt = '0;
          ovf_nxt  = 1'b0;
        end
        glcm_pkg::OP_POSINC: begin
          pos_nxt = pos_r + 1'b1;
        end
        glcm_pkg::OP_PAD: begin
          ov_nxt       = 1'b1;
          ov_value_nxt = '0;
          ov_mult_nxt  = 1'b0;
          ov_flag_nxt  = 1'b0;
          ov_last_nxt  = 1'b0;
          mult_nxt     = '0;
          ovf_nxt      = 1'b0;
          pos_nxt      = pos_r + 1'b1;
        end
        glcm_pkg::OP_MULT: begin
          ov_nxt       = 1'b1;
          ov_value_nxt = mult_r;
          ov_mult_nxt  = 1'b1;
          ov_flag_nxt  = ovf_r;
          ov_last_nxt  = 1'b1;
          mult_nxt     = '0;
          ovf_nxt      = 1'b0;
          pos_nxt      = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= glcm_pkg::S_WAIT;
      gsize_r <= glcm_pkg::MIN_GROUP;
      mult_r  <= '0;
      pos_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      gsize_r <= gsize_nxt;
      mult_r  <= mult_nxt;
      pos_r   <= pos_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    dv_r       <= dv_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    ov_value_r <= ov_value_nxt;
    ov_mult_r  <= ov_mult_nxt;
    ov_flag_r  <= ov_flag_nxt;
    ov_last_r  <= ov_last_nxt;
  end

  `ASSERT_SAME(a_sat_flag, clk, rst_n, ovf_r, mult_r == '1)
  `ASSERT_SAME(a_mult_ends_run, clk, rst_n, ov_r && ov_mult_r, ov_last_r)
  `ASSERT_SAME(a_div_nonzero, clk, rst_n, ctrl.op == glcm_pkg::OP_DIV_STP, dv_r != '0)
  `ASSERT_SAME(a_pos_open, clk, rst_n, ctrl.op == glcm_pkg::OP_WAIT,
               pos_r < glcm_pkg::MAX_GROUP)
  `ASSERT_NEXT(a_pad_then_zero, clk, rst_n,
               ctrl.op == glcm_pkg::OP_PAD && !stall, mult_r == '0 && !ovf_r)

endmodule

`default_nettype wire

@@ bench/group_lcm_checker.sv @@
`default_nettype none

module group_lcm_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [glcm_pkg::GSIZE_W-1:0] cfg_wdata,
  glcm_in_if                                in_ch,
  glcm_out_if                               out_ch,
  output int                                fail_count,
  output int                                words_pending,
  output int                                multiples_seen,
  output int                                saturated_seen
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [glcm_pkg::DATA_W-1:0] value;
    logic                        is_multiple;
    logic                        saturated;
    logic                        last_word;
  } lcm_word_t;

  lcm_word_t                    expected_words[$];
  logic [glcm_pkg::GSIZE_W-1:0] group_size_reg;
  logic [glcm_pkg::GSIZE_W-1:0] fill;
  logic [glcm_pkg::DATA_W-1:0]  group_lcm;
  logic                         lcm_saturated;
  int                           mismatches = 0;
  int                           multiples = 0;
  int                           saturated = 0;

  initial begin
    fail_count     = 0;
    words_pending  = 0;
    multiples_seen = 0;
    saturated_seen = 0;
  end

  function automatic logic [31:0] gcd32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] t;
    while (a != 32'd0) begin
      t = b % a;
      b = a;
      a = t;
    end
    return b;
  endfunction

  task automatic push_word(input logic [31:0] v, input logic mult, input logic sat,
                           input logic fin);
    lcm_word_t w;
    w.value       = v;
    w.is_multiple = mult;
    w.saturated   = sat;
    w.last_word   = fin;
    expected_words.push_back(w);
  endtask

  // fold one value into the open group
  task automatic absorb(input logic [31:0] v);
    logic [31:0] g;
    logic [63:0] p;
    if (fill == '0) begin
      group_lcm     = v;
      lcm_saturated = 1'b0;
    end else if (v == 32'd0 || group_lcm == 32'd0) begin
      group_lcm     = 32'd0;
      lcm_saturated = 1'b0;
    end else if (!lcm_saturated) begin
      g = gcd32(group_lcm, v);
      p = 64'(group_lcm / g) * 64'(v);
      if (p > 64'h0000_0000_FFFF_FFFF) begin
        group_lcm     = 32'hFFFF_FFFF;
        lcm_saturated = 1'b1;
      end else begin
        group_lcm = p[31:0];
      end
    end
    fill = fill + 1'b1;
  endtask

  task automatic close_group();
    push_word(group_lcm, 1'b1, lcm_saturated, 1'b1);
    fill          = '0;
    group_lcm     = '0;
    lcm_saturated = 1'b0;
  endtask

  task automatic predict_words(input logic [15:0] v, input logic fin);
    logic [glcm_pkg::GSIZE_W-1:0] size;
    size = (group_size_reg < glcm_pkg::MIN_GROUP) ? glcm_pkg::MIN_GROUP : group_size_reg;
    absorb(32'(v));
    push_word(32'(v), 1'b0, 1'b0, !(fill >= size || fin));
    if (fill >= size) begin
      close_group();
    end else if (fin) begin
      while (fill < size) begin
        push_word(32'd0, 1'b0, 1'b0, 1'b0);
        absorb(32'd0);
      end
      close_group();
    end
  endtask

  task automatic check_word();
    lcm_word_t want;
    if (expected_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected word: value %h mult %b sat %b last %b", out_ch.out_value,
                 out_ch.is_multiple, out_ch.overflowed, out_ch.last_of_run);
    end else begin
      want = expected_words.pop_front();
      if (want.value !== out_ch.out_value || want.is_multiple !== out_ch.is_multiple ||
          want.saturated !== out_ch.overflowed || want.last_word !== out_ch.last_of_run) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected value %h mult %b sat %b last %b, got %h %b %b %b",
                   want.value, want.is_multiple, want.saturated, want.last_word,
                   out_ch.out_value, out_ch.is_multiple, out_ch.overflowed,
                   out_ch.last_of_run);
      end
      if (want.is_multiple) begin
        multiples++;
        if (want.saturated)
          saturated++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      group_size_reg = glcm_pkg::MIN_GROUP;
      fill           = '0;
      group_lcm      = '0;
      lcm_saturated  = 1'b0;
      expected_words.delete();
    end else begin
      if (cfg_we)
        group_size_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        predict_words(in_ch.value, in_ch.last_item);
      if (out_ch.valid && out_ch.ready)
        check_word();
    end
    fail_count     <= mismatches;
    words_pending  <= expected_words.size();
    multiples_seen <= multiples;
    saturated_seen <= saturated;
  end

endmodule

`default_nettype wire

@@ bench/group_lcm_appender_top_test.sv @@
`default_nettype none

module group_lcm_appender_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [glcm_pkg::GSIZE_W-1:0] cfg_wdata;
  logic                         steady = 1'b0;
  int                           fail_count;
  int                           words_pending;
  int                           multiples_seen;
  int                           saturated_seen;
  int                           words_sent = 0;
  int                           sizes_written = 0;

  glcm_in_if  in_ch ();
  glcm_out_if out_ch ();

  group_lcm_appender_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  group_lcm_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .words_pending  (words_pending),
    .multiples_seen (multiples_seen),
    .saturated_seen (saturated_seen)
  );

  wire moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic write_group_size(input logic [glcm_pkg::GSIZE_W-1:0] sz);
    cfg_we    <= 1'b1;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sizes_written++;
  endtask

  task automatic send_word(input logic [15:0] v, input logic fin);
    if (!steady && $urandom_range(2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.last_item <= fin;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // wait until every expected word is out and the block is idle, then let it go quiet
  task automatic settle(input int drain);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0 || !in_ch.ready);
    repeat (drain) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(65535));
      4: begin
        case ($urandom_range(3))
          0:       return 16'd65521;
          1:       return 16'd65519;
          2:       return 16'd65497;
          default: return 16'd65479;
        endcase
      end
      default: return 16'($urandom_range(24, 1));
    endcase
  endfunction

  initial begin : result_backpressure
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || moved)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("group_lcm_appender_top_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [glcm_pkg::GSIZE_W-1:0] sz;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.last_item <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset group size: full-scale pair, zero in group, short and exact final groups
    send_word(16'hFFFF, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'd5, 1'b0);
    send_word(16'd7, 1'b1);
    send_word(16'd3, 1'b0);
    send_word(16'd4, 1'b1);

    // saturation, zero clearing it, then an open group of three
    settle(32);
    write_group_size(4'd4);
    send_word(16'd65521, 1'b0);
    send_word(16'd65519, 1'b0);
    send_word(16'd65497, 1'b0);
    send_word(16'd0, 1'b0);
    send_word(16'd65521, 1'b0);
    send_word(16'd65519, 1'b0);
    send_word(16'd65497, 1'b0);
    send_word(16'd2, 1'b0);
    send_word(16'd1, 1'b0);
    send_word(16'd1, 1'b0);
    send_word(16'd1, 1'b0);

    // shrink below the open group, it closes on the next word
    settle(32);
    write_group_size(4'd2);
    send_word(16'd9, 1'b0);

    settle(32);
    write_group_size(4'd0);
    send_word(16'd6, 1'b0);
    send_word(16'd10, 1'b0);

    // longest padding run
    settle(32);
    write_group_size(glcm_pkg::MAX_GROUP);
    send_word(16'hFFFF, 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      settle(32);
      if (ph == 6)
        steady <= 1'b1;
      case (ph)
        0:       sz = 4'd2;
        1:       sz = glcm_pkg::MAX_GROUP;
        2:       sz = 4'd1;
        3:       sz = 4'd3;
        4:       sz = 4'd0;
        default: sz = 4'($urandom_range(15, 2));
      endcase
      write_group_size(sz);
      repeat (27) send_word(pick_value(), $urandom_range(9) == 0);
    end

    settle(400);
    $display("covered %0d input words and %0d group multiples, %0d of them saturated",
             words_sent, multiples_seen, saturated_seen);
    $display("group size written %0d times, from below the minimum up to the maximum",
             sizes_written);
    if (fail_count == 0)
      $display("group_lcm_appender_top_test OK");
    else
      $display("group_lcm_appender_top_test NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/glcm_pkg.sv
rtl/glcm_if.sv
rtl/group_lcm_appender_top.sv
bench/group_lcm_checker.sv
bench/group_lcm_appender_top_test.sv
